// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define RSPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RSPE_ASSERT_NEXT(label, ante, cons, msg) \
    `RSPE_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/rspe_pkg.sv =====
package rspe_pkg;

    localparam int MAX_PARITY_DEF = 32;
    localparam int CFG_W = 6;
    localparam int MSG_CNT_W = 8;
    localparam int MAX_CODE_LEN = 255;
    localparam logic [8:0] FIELD_POLY = 9'h11D;
    localparam logic [CFG_W-1:0] PARITY_RESET = 6'd10;

    typedef struct packed {
        logic load;
        logic error;
    } dump_ctl_t;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] r;
        r = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY[7:0] : 8'h00);
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x = a;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/rspe_gen_builder.sv =====
module rspe_gen_builder #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
    localparam int NW = $clog2(MAX_PARITY + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rspe_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           msg_idle,
    input  logic                           msg_done,
    output logic [MAX_PARITY-1:0][7:0]     gen,
    output logic [NW-1:0]                  n_active,
    output logic                           busy
);
    import rspe_pkg::*;

    function automatic logic [NW-1:0] clamp_n(input logic [CFG_W-1:0] v);
        logic [NW-1:0] r;
        if (v == '0)
        begin
            r = NW'(1);
        end
        else if (int'(v) > MAX_PARITY)
        begin
            r = NW'(MAX_PARITY);
        end
        else
        begin
            r = NW'(v);
        end
        return r;
    endfunction

    logic [CFG_W-1:0]              pending_reg, pending_next;
    logic [MAX_PARITY-1:0][7:0]    gen_reg, gen_next;
    logic [MAX_PARITY-1:0][7:0]    step_gen;
    logic [7:0]                    root_reg, root_next;
    logic [NW-1:0]                 steps_reg, steps_next;
    logic [NW-1:0]                 n_reg, n_next;
    logic                          busy_reg, busy_next;
    logic                          start;
    logic [NW-1:0]                 start_n;

    always_comb
    begin
        start = msg_done || (cfg_write && msg_idle);
        start_n = clamp_n(msg_done ? pending_reg : cfg_data);
        pending_next = cfg_write ? cfg_data : pending_reg;

        // multiply the running product by (x + root)
        step_gen[0] = gen_reg[0] ^ root_reg;
        for (int k = 1; k < MAX_PARITY; k++)
        begin
            step_gen[k] = gen_reg[k] ^ gf_mul(gen_reg[k-1], root_reg);
        end

        gen_next = gen_reg;
        root_next = root_reg;
        steps_next = steps_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        if (start)
        begin
            gen_next = '0;
            root_next = 8'h01;
            steps_next = start_n;
            n_next = start_n;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            gen_next = step_gen;
            root_next = gf_xtime(root_reg);
            steps_next = steps_reg - NW'(1);
            busy_next = (steps_reg != NW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= PARITY_RESET;
            gen_reg <= '0;
            root_reg <= 8'h01;
            steps_reg <= clamp_n(PARITY_RESET);
            n_reg <= clamp_n(PARITY_RESET);
            busy_reg <= 1'b1;
        end
        else
        begin
            pending_reg <= pending_next;
            gen_reg <= gen_next;
            root_reg <= root_next;
            steps_reg <= steps_next;
            n_reg <= n_next;
            busy_reg <= busy_next;
        end
    end

    assign gen = gen_reg;
    assign n_active = n_reg;
    assign busy = busy_reg;

endmodule

// ===== hw/rtl/rspe_remainder.sv =====
module rspe_remainder #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
    localparam int NW = $clog2(MAX_PARITY + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [MAX_PARITY-1:0][7:0]     gen,
    input  logic [NW-1:0]                  n_active,
    output logic [MAX_PARITY-1:0][7:0]     rem_upd,
    output rspe_pkg::dump_ctl_t            dump_ctl,
    output logic                           msg_idle
);
    import rspe_pkg::*;

    logic [MAX_PARITY-1:0][7:0]    rem_reg, rem_next;
    logic [MSG_CNT_W-1:0]          count_reg, count_next, count_inc;
    logic                          ovf_reg, ovf_next, ovf_inc;
    logic [7:0]                    fb;
    logic [MSG_CNT_W:0]            total;

    always_comb
    begin
        fb = data_byte ^ rem_reg[0];
        for (int j = 0; j < MAX_PARITY - 1; j++)
        begin
            rem_upd[j] = rem_reg[j+1] ^ gf_mul(gen[j], fb);
        end
        rem_upd[MAX_PARITY-1] = gf_mul(gen[MAX_PARITY-1], fb);

        ovf_inc = ovf_reg || (count_reg == MSG_CNT_W'(MAX_CODE_LEN));
        count_inc = (count_reg == MSG_CNT_W'(MAX_CODE_LEN)) ? count_reg
                                                            : count_reg + MSG_CNT_W'(1);
        total = {1'b0, count_inc} + (MSG_CNT_W + 1)'(n_active);

        dump_ctl.load = accept && last_byte;
        dump_ctl.error = ovf_inc || (total > (MSG_CNT_W + 1)'(MAX_CODE_LEN));

        rem_next = rem_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                rem_next = '0;
                count_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                rem_next = rem_upd;
                count_next = count_inc;
                ovf_next = ovf_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
        end
    end

    assign msg_idle = (count_reg == '0) && !ovf_reg;

endmodule

// ===== hw/rtl/rspe_parity_out.sv =====
module rspe_parity_out #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF,
    localparam int NW = $clog2(MAX_PARITY + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rspe_pkg::dump_ctl_t            dump_ctl,
    input  logic [MAX_PARITY-1:0][7:0]     rem,
    input  logic [NW-1:0]                  n_active,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [7:0]                     parity_byte,
    output logic                           last_parity,
    output logic                           length_error,
    output logic                           busy
);
    import rspe_pkg::*;

    logic [MAX_PARITY-1:0][7:0]    par_reg, par_next;
    logic [NW-1:0]                 cnt_reg, cnt_next;
    logic                          err_reg, err_next;

    always_comb
    begin
        par_next = par_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (dump_ctl.load)
        begin
            if (dump_ctl.error)
            begin
                par_next = '0;
                cnt_next = NW'(1);
                err_next = 1'b1;
            end
            else
            begin
                par_next = rem;
                cnt_next = n_active;
                err_next = 1'b0;
            end
        end
        else if ((cnt_reg != '0) && !out_stall)
        begin
            // advance to the next lower degree
            par_next = par_reg >> 8;
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        par_reg <= par_next;
    end

    assign out_valid = (cnt_reg != '0);
    assign parity_byte = par_reg[0];
    assign last_parity = (cnt_reg == NW'(1));
    assign length_error = err_reg;
    assign busy = (cnt_reg != '0);

endmodule

// ===== hw/rtl/reed_solomon_parity_encoder_unit.sv =====
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// cfg       | cfg_write            | cfg_data
// in        | in_valid / in_stall  | data_byte, last_byte
// out       | out_valid / out_stall| parity_byte, last_parity, length_error
//
// One message byte per cycle while in_stall is low, set by the combinational
// remainder update (a GF multiplier per tap). After reset, after each final byte
// and after a parity count write while idle, the generator is rebuilt for n, the
// clamped parity count, while input stalls. A final byte stalls while the previous
// parity words are still draining; n words (one on a length error) then
// follow from the next cycle, one per cycle that out_stall allows.
`include "assert_macros.svh"

module reed_solomon_parity_encoder_unit #(
    parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rspe_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     parity_byte,
    output logic                           last_parity,
    output logic                           length_error
);
    import rspe_pkg::*;

    localparam int NW = $clog2(MAX_PARITY + 1);

    logic [MAX_PARITY-1:0][7:0]    gen;
    logic [MAX_PARITY-1:0][7:0]    rem_upd;
    logic [NW-1:0]                 n_active;
    logic                          build_busy;
    logic                          dump_busy;
    logic                          msg_idle;
    logic                          in_accept;
    dump_ctl_t                     dump_ctl;

    assign in_stall = build_busy || (dump_busy && last_byte);
    assign in_accept = in_valid && !in_stall;

    rspe_gen_builder #(
        .MAX_PARITY(MAX_PARITY)
    ) u_gen (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .msg_idle(msg_idle),
        .msg_done(dump_ctl.load),
        .gen(gen),
        .n_active(n_active),
        .busy(build_busy)
    );

    rspe_remainder #(
        .MAX_PARITY(MAX_PARITY)
    ) u_rem (
        .clk(clk),
        .rst_n(rst_n),
        .accept(in_accept),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .gen(gen),
        .n_active(n_active),
        .rem_upd(rem_upd),
        .dump_ctl(dump_ctl),
        .msg_idle(msg_idle)
    );

    rspe_parity_out #(
        .MAX_PARITY(MAX_PARITY)
    ) u_out (
        .clk(clk),
        .rst_n(rst_n),
        .dump_ctl(dump_ctl),
        .rem(rem_upd),
        .n_active(n_active),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .parity_byte(parity_byte),
        .last_parity(last_parity),
        .length_error(length_error),
        .busy(dump_busy)
    );

    `RSPE_ASSERT_NEXT(a_last_gives_word, in_accept && last_byte, out_valid,
        "final byte produced no parity word")
    `RSPE_ASSERT_NEXT(a_rebuild_after_msg, in_accept && last_byte, build_busy,
        "generator not rebuilt after message")
    `RSPE_ASSERT(a_error_is_final, (out_valid && length_error) |-> last_parity,
        "length error word not marked final")

endmodule
